// ===== src/tfd_pkg.sv =====
package tfd_pkg;

  localparam logic [7:0] FRAME_OPEN = 8'h3C;
  localparam logic [7:0] TYPE_BOOL  = 8'h62;
  localparam logic [7:0] TYPE_INT   = 8'h69;
  localparam logic [7:0] TYPE_FLOAT = 8'h66;
  localparam logic [7:0] TYPE_DBL   = 8'h64;

  localparam logic [1:0] KIND_BOOL  = 2'd0;
  localparam logic [1:0] KIND_INT   = 2'd1;
  localparam logic [1:0] KIND_FLOAT = 2'd2;
  localparam logic [1:0] KIND_DBL   = 2'd3;

  typedef struct packed {
    logic        sum_ok;
    logic [31:0] stamp;
    logic [55:0] tag_text;
    logic [1:0]  kind;
    logic [63:0] payload;
  } frame_t;

  typedef struct packed {
    logic at_end;
  } parse_status_t;

  // true where a data byte at this position is stored for the given kind
  function automatic logic byte_kept(input logic [1:0] kind, input logic [2:0] idx);
    logic kept;
    case (kind)
      KIND_BOOL: kept = (idx == 3'd0);
      KIND_DBL:  kept = 1'b1;
      default:   kept = ~idx[2];
    endcase
    return kept;
  endfunction

endpackage

// ===== src/tfd_ifs.sv =====
interface tfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface tfd_frame_if;
  logic        valid;
  logic        ready;
  logic        sum_ok;
  logic [31:0] stamp;
  logic [55:0] tag_text;
  logic [1:0]  kind;
  logic [63:0] payload;

  modport source(output valid, output sum_ok, output stamp, output tag_text,
                 output kind, output payload, input ready);
  modport sink(input valid, input sum_ok, input stamp, input tag_text,
               input kind, input payload, output ready);
endinterface

// ===== src/tfd_parse.sv =====
module tfd_parse (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [7:0]             rx_byte,
  output tfd_pkg::parse_status_t status,
  output logic                   res_valid,
  output tfd_pkg::frame_t        res
);

  typedef enum logic [3:0] {
    PH_HUNT  = 4'd0,
    PH_CSUM  = 4'd1,
    PH_STAMP = 4'd2,
    PH_TAG   = 4'd3,
    PH_TYPE  = 4'd4,
    PH_DATA  = 4'd5,
    PH_END   = 4'd6
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  byte_index, byte_index_next;
  logic [15:0] rx_sum, rx_sum_next;
  logic [15:0] calc_sum, calc_sum_next;
  logic [31:0] stamp_reg, stamp_reg_next;
  logic [55:0] tag_reg, tag_reg_next;
  logic [1:0]  kind_reg, kind_reg_next;
  logic [63:0] value_reg, value_reg_next;
  logic [15:0] sum_add;

  assign sum_add = calc_sum + {8'd0, rx_byte};

  always_comb begin
    phase_next      = phase;
    byte_index_next = byte_index;
    rx_sum_next     = rx_sum;
    calc_sum_next   = calc_sum;
    stamp_reg_next  = stamp_reg;
    tag_reg_next    = tag_reg;
    kind_reg_next   = kind_reg;
    value_reg_next  = value_reg;
    if (accept) begin
      unique case (phase)
        PH_CSUM: begin
          rx_sum_next[byte_index[0]*8 +: 8] = rx_byte;
          if (byte_index[0]) begin
            byte_index_next = 3'd0;
            phase_next      = PH_STAMP;
          end else begin
            byte_index_next = byte_index + 3'd1;
          end
        end
        PH_STAMP: begin
          calc_sum_next = sum_add;
          stamp_reg_next[byte_index[1:0]*8 +: 8] = rx_byte;
          if (byte_index[1:0] == 2'd3) begin
            byte_index_next = 3'd0;
            phase_next      = PH_TAG;
          end else begin
            byte_index_next = byte_index + 3'd1;
          end
        end
        PH_TAG: begin
          calc_sum_next = sum_add;
          if (byte_index != 3'd7) tag_reg_next[byte_index*8 +: 8] = rx_byte;
          if (byte_index >= 3'd6) begin
            byte_index_next = 3'd0;
            phase_next      = PH_TYPE;
          end else begin
            byte_index_next = byte_index + 3'd1;
          end
        end
        PH_TYPE: begin
          calc_sum_next = sum_add;
          // unknown type bytes are summed and the phase waits for another
          if (rx_byte == tfd_pkg::TYPE_BOOL || rx_byte == tfd_pkg::TYPE_INT ||
              rx_byte == tfd_pkg::TYPE_FLOAT || rx_byte == tfd_pkg::TYPE_DBL) begin
            phase_next      = PH_DATA;
            byte_index_next = 3'd0;
            value_reg_next  = '0;
            case (rx_byte)
              tfd_pkg::TYPE_BOOL:  kind_reg_next = tfd_pkg::KIND_BOOL;
              tfd_pkg::TYPE_INT:   kind_reg_next = tfd_pkg::KIND_INT;
              tfd_pkg::TYPE_FLOAT: kind_reg_next = tfd_pkg::KIND_FLOAT;
              default:             kind_reg_next = tfd_pkg::KIND_DBL;
            endcase
          end
        end
        PH_DATA: begin
          calc_sum_next = sum_add;
          if (tfd_pkg::byte_kept(kind_reg, byte_index))
            value_reg_next[byte_index*8 +: 8] = rx_byte;
          if (byte_index == 3'd7) begin
            byte_index_next = 3'd0;
            phase_next      = PH_END;
          end else begin
            byte_index_next = byte_index + 3'd1;
          end
        end
        PH_END: begin
          // closing byte is not checked and not summed
          phase_next      = PH_HUNT;
          byte_index_next = 3'd0;
          calc_sum_next   = '0;
        end
        default: begin
          if (rx_byte == tfd_pkg::FRAME_OPEN) begin
            phase_next      = PH_CSUM;
            byte_index_next = 3'd0;
            rx_sum_next     = '0;
            calc_sum_next   = '0;
            stamp_reg_next  = '0;
            tag_reg_next    = '0;
            value_reg_next  = '0;
          end else begin
            phase_next = PH_HUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      byte_index <= 3'd0;
      calc_sum   <= '0;
      kind_reg   <= '0;
    end else begin
      phase      <= phase_next;
      byte_index <= byte_index_next;
      calc_sum   <= calc_sum_next;
      kind_reg   <= kind_reg_next;
    end
    rx_sum    <= rx_sum_next;
    stamp_reg <= stamp_reg_next;
    tag_reg   <= tag_reg_next;
    value_reg <= value_reg_next;
  end

  assign status.at_end = (phase == PH_END);
  assign res_valid     = accept && (phase == PH_END);
  assign res.sum_ok    = (rx_sum == calc_sum);
  assign res.stamp     = stamp_reg;
  assign res.tag_text  = tag_reg;
  assign res.kind      = kind_reg;
  assign res.payload   = value_reg;

  a_end_clears_sum: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_END |=> phase == PH_HUNT && calc_sum == 16'd0)
    else $error("closing beat did not return to hunting with a cleared sum");

  a_stray_dropped: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_HUNT && rx_byte != tfd_pkg::FRAME_OPEN |=> phase == PH_HUNT)
    else $error("stray beat while hunting left the hunt");

  a_tag_index: assert property (@(posedge clk) disable iff (rst)
    phase == PH_TAG |-> byte_index != 3'd7)
    else $error("tag byte position out of range");

endmodule

// ===== src/tfd_out_reg.sv =====
module tfd_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  tfd_pkg::frame_t din,
  output logic            full,
  tfd_frame_if.source     frame
);

  tfd_pkg::frame_t data;
  logic            valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (frame.ready) begin
      valid <= 1'b0;
    end
    if (load) data <= din;
  end

  assign full           = valid;
  assign frame.valid    = valid;
  assign frame.sum_ok   = data.sum_ok;
  assign frame.stamp    = data.stamp;
  assign frame.tag_text = data.tag_text;
  assign frame.kind     = data.kind;
  assign frame.payload  = data.payload;

endmodule

// ===== src/telemetry_frame_deframer_core.sv =====
// result path: a frame result is loaded into the output register on its closing byte beat and shows in the cycle after
// throughput: one byte per cycle; the parser state registers take a beat every cycle
// the only stall is a closing byte meeting a result still held in the output register
// reset (synchronous, rst high): parser hunts for the start byte, output register empty
module telemetry_frame_deframer_core (
  input logic         clk,
  input logic         rst,
  tfd_byte_if.sink    rx,
  tfd_frame_if.source frame
);

  tfd_pkg::parse_status_t status;
  tfd_pkg::frame_t        res;
  logic                   res_valid;
  logic                   full;
  logic                   accept;

  // only the closing byte needs room in the output register
  assign rx.ready = !(status.at_end && full && !frame.ready);
  assign accept   = rx.valid && rx.ready;

  tfd_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx.rx_byte),
    .status    (status),
    .res_valid (res_valid),
    .res       (res)
  );

  tfd_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (res_valid),
    .din   (res),
    .full  (full),
    .frame (frame)
  );

endmodule

// ===== tb/tb_telemetry_frame_deframer_core.sv =====
module tb_telemetry_frame_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET   = 1450;
  localparam int IDLE_LIMIT    = 200;
  localparam int SETTLE_CYCLES = 10;
  localparam int WRAP_UNKNOWN  = 270;

  typedef enum logic [2:0] {
    PS_HUNT, PS_CSUM, PS_STAMP, PS_TAG, PS_TYPE, PS_DATA, PS_CLOSE
  } parse_state_e;

  typedef struct packed {
    logic       hold;  // marker: send nothing until every frame is out
    logic       calm;
    logic [7:0] value;
  } rx_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tfd_byte_if  rx ();
  tfd_frame_if frame ();

  telemetry_frame_deframer_core dut (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .frame (frame)
  );

  always #6 clk = ~clk;

  rx_beat_t          byte_q[$];
  tfd_pkg::frame_t   frames_due[$];
  logic [7:0]        body_q[$];
  int                type_pos;
  bit                calm_gen;
  int                bytes_queued;

  bit byte_beat;
  bit frame_beat;
  bit calm_now;
  int gap_left;
  int stall_left;
  int quiet_cycles;
  int errors;

  // predictor state
  parse_state_e parse_state = PS_HUNT;
  logic [2:0]   field_idx   = '0;
  logic [15:0]  sent_sum    = '0;
  logic [15:0]  byte_sum    = '0;
  logic [31:0]  stamp_acc   = '0;
  logic [55:0]  tag_acc     = '0;
  logic [1:0]   kind_acc    = '0;
  logic [63:0]  value_acc   = '0;

  int frames_checked;
  int sums_good;
  int sums_bad;
  int unknown_seen;
  int strays_seen;
  int kind_seen[4];

  task automatic report_mismatch(input string msg);
    $display("[%0t] frame %0d: %s", $time, frames_checked, msg);
    errors++;
  endtask

  task automatic advance_parser(input logic [7:0] b);
    tfd_pkg::frame_t done;
    bit              keep;
    case (parse_state)
      PS_CSUM: begin
        if (field_idx[0]) begin
          sent_sum[15:8] = b;
          field_idx = '0;
          parse_state = PS_STAMP;
        end else begin
          sent_sum[7:0] = b;
          field_idx = 3'd1;
        end
      end
      PS_STAMP: begin
        byte_sum += {8'd0, b};
        stamp_acc[field_idx[1:0]*8 +: 8] = b;
        if (field_idx == 3'd3) begin
          field_idx = '0;
          parse_state = PS_TAG;
        end else begin
          field_idx++;
        end
      end
      PS_TAG: begin
        byte_sum += {8'd0, b};
        tag_acc[field_idx*8 +: 8] = b;
        if (field_idx == 3'd6) begin
          field_idx = '0;
          parse_state = PS_TYPE;
        end else begin
          field_idx++;
        end
      end
      PS_TYPE: begin
        byte_sum += {8'd0, b};
        parse_state = PS_DATA;
        field_idx = '0;
        value_acc = '0;
        case (b)
          tfd_pkg::TYPE_BOOL:  kind_acc = tfd_pkg::KIND_BOOL;
          tfd_pkg::TYPE_INT:   kind_acc = tfd_pkg::KIND_INT;
          tfd_pkg::TYPE_FLOAT: kind_acc = tfd_pkg::KIND_FLOAT;
          tfd_pkg::TYPE_DBL:   kind_acc = tfd_pkg::KIND_DBL;
          default: begin
            // unrecognised type: summed, still waiting for a type byte
            parse_state = PS_TYPE;
            unknown_seen++;
          end
        endcase
      end
      PS_DATA: begin
        byte_sum += {8'd0, b};
        keep = (kind_acc == tfd_pkg::KIND_DBL) || (field_idx == 3'd0) ||
               (kind_acc != tfd_pkg::KIND_BOOL && field_idx < 3'd4);
        if (keep) value_acc[field_idx*8 +: 8] = b;
        if (field_idx == 3'd7) begin
          field_idx = '0;
          parse_state = PS_CLOSE;
        end else begin
          field_idx++;
        end
      end
      PS_CLOSE: begin
        done.sum_ok   = (sent_sum == byte_sum);
        done.stamp    = stamp_acc;
        done.tag_text = tag_acc;
        done.kind     = kind_acc;
        done.payload  = value_acc;
        frames_due.push_back(done);
        parse_state = PS_HUNT;
        field_idx = '0;
        byte_sum = '0;
      end
      default: begin
        if (b == tfd_pkg::FRAME_OPEN) begin
          parse_state = PS_CSUM;
          field_idx = '0;
          sent_sum = '0;
          byte_sum = '0;
          stamp_acc = '0;
          tag_acc = '0;
          value_acc = '0;
        end else begin
          strays_seen++;
        end
      end
    endcase
  endtask

  task automatic check_frame();
    tfd_pkg::frame_t want;
    if (frames_due.size() == 0) begin
      report_mismatch($sformatf("unexpected frame, stamp %h", frame.stamp));
      return;
    end
    want = frames_due.pop_front();
    if (frame.sum_ok !== want.sum_ok)
      report_mismatch($sformatf("sum_ok got %b want %b", frame.sum_ok, want.sum_ok));
    if (frame.stamp !== want.stamp)
      report_mismatch($sformatf("stamp got %h want %h", frame.stamp, want.stamp));
    if (frame.tag_text !== want.tag_text)
      report_mismatch($sformatf("tag_text got %h want %h", frame.tag_text, want.tag_text));
    if (frame.kind !== want.kind)
      report_mismatch($sformatf("kind got %0d want %0d", frame.kind, want.kind));
    if (frame.payload !== want.payload)
      report_mismatch($sformatf("payload got %h want %h", frame.payload, want.payload));
    frames_checked++;
    if (want.sum_ok) sums_good++;
    else sums_bad++;
    kind_seen[want.kind]++;
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    byte_beat = 1'b0;
    frame_beat = 1'b0;
    if (!rst) begin
      frame_beat = frame.valid && frame.ready;
      byte_beat = rx.valid && rx.ready;
      if (frame_beat) check_frame();
      if (byte_beat) advance_parser(rx.rx_byte);
      if (frame_beat || byte_beat) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // byte driver
  always @(negedge clk) begin
    rx_beat_t head;
    if (rst) begin
      rx.valid <= 1'b0;
    end else if (rx.valid && !byte_beat) begin
      // beat still waiting for ready
    end else if (byte_q.size() == 0) begin
      rx.valid <= 1'b0;
    end else if (byte_q[0].hold) begin
      rx.valid <= 1'b0;
      if (frames_due.size() == 0) void'(byte_q.pop_front());
    end else if (gap_left > 0) begin
      rx.valid <= 1'b0;
      gap_left--;
    end else begin
      head = byte_q.pop_front();
      calm_now = head.calm;
      rx.valid <= 1'b1;
      rx.rx_byte <= head.value;
      gap_left = head.calm ? 0 : $urandom_range(0, 5);
    end
  end

  // frame receiver back-pressure
  always @(negedge clk) begin
    if (rst) begin
      frame.ready <= 1'b0;
    end else begin
      if (frame_beat) stall_left = calm_now ? 0 : $urandom_range(0, 5);
      if (stall_left > 0) begin
        frame.ready <= 1'b0;
        stall_left--;
      end else begin
        frame.ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 3) return 8'h00;
    if (pick < 6) return 8'hFF;
    if (pick < 8) return tfd_pkg::FRAME_OPEN;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] unknown_type();
    logic [7:0] v;
    do v = rand_byte();
    while (v == tfd_pkg::TYPE_BOOL || v == tfd_pkg::TYPE_INT ||
           v == tfd_pkg::TYPE_FLOAT || v == tfd_pkg::TYPE_DBL);
    return v;
  endfunction

  function automatic logic [7:0] random_type();
    case ($urandom_range(0, 3))
      0:       return tfd_pkg::TYPE_BOOL;
      1:       return tfd_pkg::TYPE_INT;
      2:       return tfd_pkg::TYPE_FLOAT;
      default: return tfd_pkg::TYPE_DBL;
    endcase
  endfunction

  task automatic send(input logic [7:0] v, input bit counted);
    rx_beat_t item;
    item.hold = 1'b0;
    item.calm = calm_gen;
    item.value = v;
    byte_q.push_back(item);
    if (counted) bytes_queued++;
  endtask

  task automatic send_hold();
    rx_beat_t item;
    item.hold = 1'b1;
    item.calm = calm_gen;
    item.value = '0;
    byte_q.push_back(item);
  endtask

  // stamp, tag, unknown type bytes, type byte, eight data bytes
  task automatic build_body(input logic [7:0] type_code, input int n_unknown);
    body_q.delete();
    repeat (11) body_q.push_back(rand_byte());
    repeat (n_unknown) body_q.push_back(unknown_type());
    type_pos = body_q.size();
    body_q.push_back(type_code);
    repeat (8) body_q.push_back(rand_byte());
  endtask

  task automatic fill_body(input logic [7:0] fill);
    for (int i = 0; i < body_q.size(); i++)
      if (i != type_pos) body_q[i] = fill;
  endtask

  // cut > 0 and below the frame length stops the frame early after that many bytes
  task automatic send_frame(input logic [15:0] sum_err, input logic [7:0] closing,
                            input int cut);
    logic [15:0] total;
    logic [7:0]  whole[$];
    int          n;
    total = sum_err;
    foreach (body_q[i]) total += {8'd0, body_q[i]};
    whole.push_back(tfd_pkg::FRAME_OPEN);
    whole.push_back(total[7:0]);
    whole.push_back(total[15:8]);
    foreach (body_q[i]) whole.push_back(body_q[i]);
    whole.push_back(closing);
    n = (cut > 0 && cut < whole.size()) ? cut : whole.size();
    for (int i = 0; i < n; i++) send(whole[i], 1'b1);
  endtask

  initial begin
    wait (quiet_cycles >= IDLE_LIMIT);
    $display("tb_telemetry_frame_deframer_core failed");
    $finish;
  end

  initial begin
    int         n_unknown;
    int         cut;
    logic [15:0] sum_err;
    logic [7:0]  stray;
    bit          wrapped;

    rx.valid = 1'b0;
    rx.rx_byte = '0;
    frame.ready = 1'b0;
    wrapped = 1'b0;

    // directed frames
    calm_gen = 1'b1;
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    build_body(tfd_pkg::TYPE_BOOL, 0);
    fill_body(8'hFF);
    send_frame(16'h0000, 8'h00, 0);
    build_body(tfd_pkg::TYPE_INT, 2);
    fill_body(8'h00);
    send_frame(16'h0001, 8'hFF, 0);
    calm_gen = 1'b0;
    // start byte in every body byte but the type byte and as the closing byte, unknown types among them
    build_body(tfd_pkg::TYPE_FLOAT, 2);
    fill_body(tfd_pkg::FRAME_OPEN);
    send_frame(16'h0000, tfd_pkg::FRAME_OPEN, 0);
    build_body(tfd_pkg::TYPE_DBL, 0);
    fill_body(8'hFF);
    send_frame(16'h8000, 8'h5A, 0);
    build_body(tfd_pkg::TYPE_DBL, 1);
    send_frame(16'h0000, rand_byte(), 0);
    send_hold();

    while (bytes_queued < ITEM_TARGET) begin
      calm_gen = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          do stray = 8'($urandom_range(0, 255));
          while (stray == tfd_pkg::FRAME_OPEN);
          send(stray, 1'b0);
        end
      end
      n_unknown = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      if (!wrapped && bytes_queued > ITEM_TARGET / 2) begin
        // enough all-ones unknown types to wrap the 16-bit sum
        build_body(random_type(), WRAP_UNKNOWN);
        for (int i = 11; i < type_pos; i++) body_q[i] = 8'hFF;
        wrapped = 1'b1;
      end else begin
        build_body(random_type(), n_unknown);
      end
      sum_err = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535)) : 16'd0;
      cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, body_q.size() + 3) : 0;
      send_frame(sum_err, rand_byte(), cut);
      if ($urandom_range(0, 19) == 0) send_hold();
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (byte_q.size() != 0 || rx.valid) @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d bytes sent, %0d stray bytes dropped, %0d unknown type bytes",
             bytes_queued, strays_seen, unknown_seen);
    $display("%0d frames checked: sum good %0d bad %0d, kinds b/i/f/d %0d/%0d/%0d/%0d",
             frames_checked, sums_good, sums_bad,
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    if (errors == 0) begin
      $display("tb_telemetry_frame_deframer_core passed");
    end else begin
      $display("tb_telemetry_frame_deframer_core failed");
    end
    $finish;
  end

endmodule
